[src/civil_time_to_epoch_seconds_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the civil time conversion unit
// Short forms of the concurrent checks, clocked on clock, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef CIVIL_TIME_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH
`define CIVIL_TIME_TO_EPOCH_SECONDS_UNIT_ASSERT_SVH

// same-cycle implication
`define CTES_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define CTES_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/ctes_pkg.sv]
// ----------------------------------------------------------------------------
// ctes_pkg
// Types, codes and calendar constants of the civil time conversion unit.
// ----------------------------------------------------------------------------
package ctes_pkg;

   // item function codes
   localparam logic FUNC_LOAD    = 1'b0;
   localparam logic FUNC_CONVERT = 1'b1;

   // register indexes
   localparam int unsigned CSR_INDEX_W = 2;
   localparam logic [CSR_INDEX_W-1:0] CSR_STD_OFFSET = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DST_OFFSET = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PAIR_COUNT = 2'd2;

   localparam int unsigned OFFSET_W = 18;
   localparam int unsigned COUNT_W  = 7;
   localparam int unsigned EPOCH_W  = 32;
   localparam int unsigned ENTRY_W  = 64;
   localparam int unsigned SECS_W   = 35;   // signed running sum
   localparam int unsigned DIFF_W   = 36;   // signed sum minus offset
   localparam int unsigned YDAYS_W  = 17;
   localparam int unsigned DAYS_W   = 18;   // signed day count
   localparam int unsigned TOD_W    = 17;

   localparam logic [7:0] BASE_YEAR_OFF = 8'd70;   // 1970 as years since 1900
   localparam logic [7:0] CENTURY_2100  = 8'd200;  // 2100, not a leap year
   localparam logic [7:0] YEARS_TO_2100 = 8'd130;  // 2100 minus 1970

   localparam logic [YDAYS_W-1:0] DAYS_PER_YEAR = 17'd365;
   localparam logic [TOD_W-1:0]   SECS_PER_HOUR = 17'd3600;
   localparam logic [TOD_W-1:0]   SECS_PER_MIN  = 17'd60;
   localparam logic signed [SECS_W-1:0] SECS_PER_DAY = 35'sd86400;

   typedef logic [3:0] month_type;

   // days in the months before the given one; month saturates at December
   function automatic logic [8:0] days_before_month(input month_type month,
                                                    input logic leap);
      logic [8:0] base;
      begin
         case (month)
            4'd0:    base = 9'd0;
            4'd1:    base = 9'd31;
            4'd2:    base = 9'd59;
            4'd3:    base = 9'd90;
            4'd4:    base = 9'd120;
            4'd5:    base = 9'd151;
            4'd6:    base = 9'd181;
            4'd7:    base = 9'd212;
            4'd8:    base = 9'd243;
            4'd9:    base = 9'd273;
            4'd10:   base = 9'd304;
            default: base = 9'd334;
         endcase
         if (leap && (month >= 4'd2)) begin
            base = base + 9'd1;
         end
         return base;
      end
   endfunction

endpackage

[src/ctes_ram.sv]
// ----------------------------------------------------------------------------
// ctes_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module ctes_ram #(
   parameter int unsigned WIDTH = 64,
   parameter int unsigned DEPTH = 64
) (
   input  logic                                         clock,
   input  logic                                         wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                             wr_data,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                             rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[src/civil_time_to_epoch_seconds_unit.sv]
// ----------------------------------------------------------------------------
// civil_time_to_epoch_seconds_unit
// Converts broken-down civil time to seconds since 1970, with a table of
// daylight-saving intervals selecting the offset to subtract.
// ----------------------------------------------------------------------------
// A convert word (func = 1) passes through four states of calendar
// arithmetic (whole years, day total, one multiply by 86400, sign check),
// then one state per interval entry read from the table RAM, at most
// min(pair_count, PAIR_DEPTH) entries, then one that forms the adjusted
// result and loads it into the result register. The request side reopens
// once the result is loaded, so no new word is taken while a convert is in
// progress. A finished result waits as long as rsp_stall holds an earlier
// result in the output register. The scan stops early at the first
// matching entry, and is skipped altogether when the standard-adjusted
// time is negative or the entry count is zero. A load word (func = 0)
// writes one table entry in the cycle it is accepted and gives no result;
// an index at or beyond PAIR_DEPTH is dropped. Table entries hold the
// start (inclusive) in the low half and the end (exclusive) in the high
// half; entries never loaded read back as anything. The result register
// lets a new word enter while a finished result still waits on rsp_stall.
// After reset both offsets and pair_count are zero, so times convert as GMT.
// ----------------------------------------------------------------------------
module civil_time_to_epoch_seconds_unit
   import ctes_pkg::*;
#(
   parameter int unsigned PAIR_DEPTH = 64
) (
   input  logic                   clock,
   input  logic                   reset,
   // configuration port
   input  logic                   csr_we,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [OFFSET_W-1:0]    csr_wdata,
   // request channel
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_func,
   input  logic [7:0]             req_year,
   input  logic [3:0]             req_month,
   input  logic [4:0]             req_day,
   input  logic [4:0]             req_hour,
   input  logic [5:0]             req_minute,
   input  logic [5:0]             req_second,
   input  logic [5:0]             req_pair_index,
   input  logic [31:0]            req_pair_start,
   input  logic [31:0]            req_pair_end,
   // response channel
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [EPOCH_W-1:0]     rsp_epoch_seconds,
   output logic                   rsp_in_daylight
);

   localparam int unsigned AW  = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
   localparam int unsigned CW  = $clog2(PAIR_DEPTH + 1);
   localparam int unsigned LW  = (CW > COUNT_W) ? CW : COUNT_W;
   localparam int unsigned IXW = (CW > 6) ? CW : 6;

   typedef enum logic [2:0] {
      S_IDLE,
      S_YEAR,
      S_DAYS,
      S_MUL,
      S_CHK,
      S_SCAN,
      S_DONE
   } state_type;

   // configuration
   logic signed [OFFSET_W-1:0] std_offset_ff;
   logic signed [OFFSET_W-1:0] dst_offset_ff;
   logic [COUNT_W-1:0]         pair_count_ff;

   // control
   state_type   state_ff, state_in;
   logic [CW-1:0] cnt_ff, cnt_in;
   logic        use_dst_ff, use_dst_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [EPOCH_W-1:0] rsp_epoch_ff, rsp_epoch_in;
   logic        rsp_dst_ff, rsp_dst_in;

   // captured fields and arithmetic pipeline
   logic [7:0]  year_ff;
   logic [3:0]  month_ff;
   logic [4:0]  day_ff;
   logic [4:0]  hour_ff;
   logic [5:0]  minute_ff;
   logic [5:0]  second_ff;
   logic [YDAYS_W-1:0]       ydays_ff;
   logic [TOD_W-1:0]         tod_ff;
   logic signed [DAYS_W-1:0] days_ff;
   logic signed [SECS_W-1:0] secs_ff;

   logic        req_accept;
   logic        load_we;
   logic [IXW-1:0] idx_ext;
   logic [LW-1:0]  pc_ext;
   logic [CW-1:0]  scan_lim;
   logic [7:0]     years_done;
   logic [7:0]     leaps_done;
   logic           past_2100;
   logic           year_leap;
   logic [YDAYS_W-1:0] ydays_in;
   logic [TOD_W-1:0]   tod_in;
   logic signed [DAYS_W-1:0] days_in;
   logic signed [SECS_W-1:0] secs_in;
   logic signed [DIFF_W-1:0] std_diff;
   logic signed [DIFF_W-1:0] res_diff;
   logic [EPOCH_W-1:0]       res_clamped;
   logic [ENTRY_W-1:0]       entry;
   logic signed [SECS_W-1:0] entry_lo;
   logic signed [SECS_W-1:0] entry_hi;
   logic                     entry_hit;
   logic                     out_free;

   // ------------------------------------------------------------------
   // Handshakes: take a word only when the sequencer is idle
   // ------------------------------------------------------------------
   assign req_stall  = (state_ff != S_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   // ------------------------------------------------------------------
   // Interval table: written by load words, scanned from entry 0 upward
   // ------------------------------------------------------------------
   assign idx_ext = IXW'(req_pair_index);
   assign load_we = req_accept && (req_func == FUNC_LOAD) &&
                    (idx_ext < IXW'(PAIR_DEPTH));

   ctes_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (PAIR_DEPTH)
   ) u_pair_ram (
      .clock   (clock),
      .wr_en   (load_we),
      .wr_addr (idx_ext[AW-1:0]),
      .wr_data ({req_pair_end, req_pair_start}),
      .rd_addr (cnt_ff[AW-1:0]),
      .rd_data (entry)
   );

   // clip the entry count to the table depth
   assign pc_ext   = LW'(pair_count_ff);
   assign scan_lim = (pc_ext < LW'(PAIR_DEPTH)) ? pc_ext[CW-1:0] : CW'(PAIR_DEPTH);

   // ------------------------------------------------------------------
   // Calendar arithmetic
   // ------------------------------------------------------------------
   // Whole years from 1970: the first leap year is 1972, and 2100 is the
   // only century in range that drops its leap day.
   assign years_done = (year_ff > BASE_YEAR_OFF) ? (year_ff - BASE_YEAR_OFF) : 8'd0;
   assign past_2100  = (years_done > YEARS_TO_2100);
   assign leaps_done = 8'((9'(years_done) + 9'd1) >> 2) - 8'(past_2100);
   assign ydays_in   = YDAYS_W'(years_done) * DAYS_PER_YEAR + YDAYS_W'(leaps_done);
   assign tod_in     = TOD_W'(hour_ff) * SECS_PER_HOUR + TOD_W'(minute_ff) * SECS_PER_MIN
                       + TOD_W'(second_ff);

   // Gregorian rule over 1900..2155: 1900 and 2100 are the non-leap centuries
   assign year_leap = (year_ff[1:0] == 2'b00) && (year_ff != 8'd0) &&
                      (year_ff != CENTURY_2100);

   assign days_in = DAYS_W'(signed'({1'b0, ydays_ff}))
                  + DAYS_W'(signed'({1'b0, days_before_month(month_ff, year_leap)}))
                  + DAYS_W'(signed'({1'b0, day_ff}))
                  - DAYS_W'(1);

   assign secs_in = SECS_W'(days_ff) * SECS_PER_DAY + SECS_W'(signed'({1'b0, tod_ff}));

   assign std_diff = DIFF_W'(secs_ff) - DIFF_W'(std_offset_ff);
   assign res_diff = DIFF_W'(secs_ff) - DIFF_W'(use_dst_ff ? dst_offset_ff : std_offset_ff);

   always_comb begin
      if (res_diff < 0) begin
         res_clamped = '0;
      end else if (res_diff[DIFF_W-1:EPOCH_W] != '0) begin
         res_clamped = '1;
      end else begin
         res_clamped = res_diff[EPOCH_W-1:0];
      end
   end

   // interval test on the entry read in the previous cycle
   assign entry_lo  = SECS_W'(signed'({1'b0, entry[31:0]}));
   assign entry_hi  = SECS_W'(signed'({1'b0, entry[63:32]}));
   assign entry_hit = (secs_ff >= entry_lo) && (secs_ff < entry_hi);

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      use_dst_in   = use_dst_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_epoch_in = rsp_epoch_ff;
      rsp_dst_in   = rsp_dst_ff;
      case (state_ff)
         S_IDLE: begin
            cnt_in     = '0;
            use_dst_in = 1'b0;
            if (req_accept && (req_func == FUNC_CONVERT)) begin
               state_in = S_YEAR;
            end
         end
         S_YEAR: state_in = S_DAYS;
         S_DAYS: state_in = S_MUL;
         S_MUL:  state_in = S_CHK;
         S_CHK: begin
            // negative standard time (result clamps to zero) or no entries: skip the table
            if ((std_diff < 0) || (scan_lim == '0)) begin
               state_in = S_DONE;
            end else begin
               cnt_in   = CW'(1);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (entry_hit) begin
               use_dst_in = 1'b1;
               state_in   = S_DONE;
            end else if (cnt_ff == scan_lim) begin
               state_in = S_DONE;
            end else begin
               cnt_in = cnt_ff + CW'(1);
            end
         end
         S_DONE: begin
            // hold the result until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_epoch_in = res_clamped;
               rsp_dst_in   = use_dst_ff;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         cnt_ff       <= '0;
         use_dst_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         use_dst_ff   <= use_dst_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_epoch_ff <= rsp_epoch_in;
      rsp_dst_ff   <= rsp_dst_in;
   end

   // capture the word and advance the arithmetic one step per state
   always_ff @(posedge clock) begin
      if (req_accept) begin
         year_ff   <= req_year;
         month_ff  <= req_month;
         day_ff    <= req_day;
         hour_ff   <= req_hour;
         minute_ff <= req_minute;
         second_ff <= req_second;
      end
      if (state_ff == S_YEAR) begin
         ydays_ff <= ydays_in;
         tod_ff   <= tod_in;
      end
      if (state_ff == S_DAYS) begin
         days_ff <= days_in;
      end
      if (state_ff == S_MUL) begin
         secs_ff <= secs_in;
      end
   end

   // configuration registers; writes beyond the list are dropped
   always_ff @(posedge clock) begin
      if (reset) begin
         std_offset_ff <= '0;
         dst_offset_ff <= '0;
         pair_count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_STD_OFFSET: std_offset_ff <= csr_wdata;
            CSR_DST_OFFSET: dst_offset_ff <= csr_wdata;
            CSR_PAIR_COUNT: pair_count_ff <= csr_wdata[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_epoch_seconds = rsp_epoch_ff;
   assign rsp_in_daylight   = rsp_dst_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
`include "civil_time_to_epoch_seconds_unit_assert.svh"

   `CTES_ASSERT_NEXT(a_convert_starts, req_accept && (req_func == FUNC_CONVERT), state_ff == S_YEAR, "convert word did not start the sequencer")
   `CTES_ASSERT_NOW(a_scan_in_range, state_ff == S_SCAN, (cnt_ff != '0) && (cnt_ff <= scan_lim), "scan index outside the entries in use")
   `CTES_ASSERT_NEXT(a_result_held, (state_ff == S_DONE) && rsp_valid_ff && rsp_stall, (state_ff == S_DONE) && rsp_valid_ff, "pending result overwritten")

endmodule

[test/tb.sv]
// ----------------------------------------------------------------------------
// tb - civil time to epoch seconds unit
// Drives convert and table-load words through the request channel, predicts
// every result from a private copy of the offsets and the daylight table,
// and compares each response word field by field in order of issue.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
   import ctes_pkg::*;

   localparam int TABLE_DEPTH   = 64;
   localparam int GAP_MAX       = 18;
   localparam int LONG_HOLD     = 400;   // receiver hold-off, in cycles
   localparam int SETTLE_CYCLES = 80;    // outlasts a convert that scans all 64 entries
   localparam int STALL_LIMIT   = 5000;  // cycles without any handshake
   localparam int PHASES        = 6;
   localparam int PHASE_WORDS   = 210;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct packed {
      logic        func;
      logic [7:0]  year;
      logic [3:0]  month;
      logic [4:0]  day;
      logic [4:0]  hour;
      logic [5:0]  minute;
      logic [5:0]  second;
      logic [5:0]  pair_index;
      logic [31:0] pair_start;
      logic [31:0] pair_end;
   } civil_word_type;

   // -------------------------------------------------------------------------
   // Offsets, daylight table and the queue of awaited epoch results
   // -------------------------------------------------------------------------
   class epoch_ledger;
      localparam longint DAY_SECS   = 86400;
      localparam int     CIVIL_BASE = 1900;
      localparam int     EPOCH_YEAR = 1970;

      typedef struct {
         logic [EPOCH_W-1:0] epoch;
         logic               daylight;
      } epoch_result_type;

      longint           std_off;
      longint           dst_off;
      int unsigned      pairs_used;
      bit [63:0]        pairs [TABLE_DEPTH];
      epoch_result_type awaited_epochs [$];
      int               errors;
      int               n_convert;
      int               n_load;
      int               n_daylight;
      int               n_clamped;

      static function bit is_leap(int y);
         return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      endfunction

      static function int month_length(int m, bit leap_yr);
         case (m)
            1:          return leap_yr ? 29 : 28;
            3, 5, 8, 10: return 30;
            default:    return 31;
         endcase
      endfunction

      // unadjusted seconds since 1970; years before 1970 add no whole years
      static function longint civil_seconds(civil_word_type w);
         int     yr;
         int     y;
         int     mo;
         int     i;
         bit     lp;
         longint total;
         yr = int'(w.year) + CIVIL_BASE;
         total = 0;
         for (y = EPOCH_YEAR; y < yr; y++) begin
            total += (is_leap(y) ? 366 : 365) * DAY_SECS;
         end
         mo = (w.month > 4'd11) ? 11 : int'(w.month);
         lp = is_leap(yr);
         for (i = 0; i < mo; i++) begin
            total += month_length(i, lp) * DAY_SECS;
         end
         total += (longint'(w.day) - 1) * DAY_SECS;
         total += longint'(w.hour) * 3600 + longint'(w.minute) * 60 + longint'(w.second);
         return total;
      endfunction

      function void set_reg(logic [CSR_INDEX_W-1:0] idx, logic [OFFSET_W-1:0] val);
         case (idx)
            CSR_STD_OFFSET: std_off = longint'($signed(val));
            CSR_DST_OFFSET: dst_off = longint'($signed(val));
            CSR_PAIR_COUNT: pairs_used = int'(val[COUNT_W-1:0]);
            default: ;
         endcase
      endfunction

      function void note_word(civil_word_type w);
         longint           secs;
         longint           lo;
         longint           hi;
         longint           adj;
         int               scan;
         int               i;
         bit               hit;
         epoch_result_type res;
         if (w.func == FUNC_LOAD) begin
            if (int'(w.pair_index) < TABLE_DEPTH) begin
               pairs[w.pair_index] = {w.pair_end, w.pair_start};
            end
            n_load++;
            return;
         end
         n_convert++;
         secs = civil_seconds(w);
         if (secs - std_off < 0) begin
            // negative standard time: zero, no table scan
            res.epoch = '0;
            res.daylight = 1'b0;
            n_clamped++;
         end else begin
            hit = 1'b0;
            scan = (pairs_used < TABLE_DEPTH) ? int'(pairs_used) : TABLE_DEPTH;
            for (i = 0; i < scan && !hit; i++) begin
               lo = longint'(pairs[i][31:0]);
               hi = longint'(pairs[i][63:32]);
               if (secs >= lo && secs < hi) begin
                  hit = 1'b1;
               end
            end
            adj = hit ? secs - dst_off : secs - std_off;
            res.daylight = hit;
            if (adj < 0) begin
               res.epoch = '0;
               n_clamped++;
            end else if (adj > longint'(32'hFFFF_FFFF)) begin
               res.epoch = '1;
               n_clamped++;
            end else begin
               res.epoch = adj[EPOCH_W-1:0];
            end
            if (hit) begin
               n_daylight++;
            end
         end
         awaited_epochs.push_back(res);
      endfunction

      task flag_error(string msg);
         $display("%0t ns  mismatch: %s", $time, msg);
         errors++;
      endtask

      task check_result(logic [EPOCH_W-1:0] epoch, logic daylight);
         epoch_result_type exp_res;
         if (awaited_epochs.size() == 0) begin
            flag_error($sformatf("result %0d/%0b with nothing awaited", epoch, daylight));
            return;
         end
         exp_res = awaited_epochs.pop_front();
         if (epoch !== exp_res.epoch) begin
            flag_error($sformatf("epoch_seconds %0d, predicted %0d", epoch, exp_res.epoch));
         end
         if (daylight !== exp_res.daylight) begin
            flag_error($sformatf("in_daylight %0b, predicted %0b", daylight,
                                 exp_res.daylight));
         end
      endtask

      function int pending();
         return awaited_epochs.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Block ports; every input holds a known value from time zero
   // -------------------------------------------------------------------------
   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [OFFSET_W-1:0]    csr_wdata = '0;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   logic                   req_func = 1'b0;
   logic [7:0]             req_year = '0;
   logic [3:0]             req_month = '0;
   logic [4:0]             req_day = '0;
   logic [4:0]             req_hour = '0;
   logic [5:0]             req_minute = '0;
   logic [5:0]             req_second = '0;
   logic [5:0]             req_pair_index = '0;
   logic [31:0]            req_pair_start = '0;
   logic [31:0]            req_pair_end = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   logic [EPOCH_W-1:0]     rsp_epoch_seconds;
   logic                   rsp_in_daylight;

   // idling controls for the sender and the receiver
   bit req_idle_on = 1'b1;
   bit rsp_idle_on = 1'b1;
   bit hold_wanted = 1'b0;
   int settings    = 0;

   epoch_ledger sb;

   civil_time_to_epoch_seconds_unit #(
      .PAIR_DEPTH (TABLE_DEPTH)
   ) i_dut (
      .clock             (clock),
      .reset             (reset),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_year          (req_year),
      .req_month         (req_month),
      .req_day           (req_day),
      .req_hour          (req_hour),
      .req_minute        (req_minute),
      .req_second        (req_second),
      .req_pair_index    (req_pair_index),
      .req_pair_start    (req_pair_start),
      .req_pair_end      (req_pair_end),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_epoch_seconds (rsp_epoch_seconds),
      .rsp_in_daylight   (rsp_in_daylight)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Word builders
   // -------------------------------------------------------------------------
   function automatic civil_word_type civil_time(int y, int mo, int d, int h, int mi, int s);
      civil_word_type w;
      w.func       = FUNC_CONVERT;
      w.year       = 8'(y);
      w.month      = 4'(mo);
      w.day        = 5'(d);
      w.hour       = 5'(h);
      w.minute     = 6'(mi);
      w.second     = 6'(s);
      w.pair_index = '0;
      w.pair_start = '0;
      w.pair_end   = '0;
      return w;
   endfunction

   // wild words use the full width of every time field
   function automatic civil_word_type rand_time(bit wild);
      civil_word_type w;
      w.func       = FUNC_CONVERT;
      w.pair_index = 6'($urandom);
      w.pair_start = $urandom;
      w.pair_end   = $urandom;
      if (wild) begin
         w.year   = 8'($urandom);
         w.month  = 4'($urandom);
         w.day    = 5'($urandom);
         w.hour   = 5'($urandom);
         w.minute = 6'($urandom);
         w.second = 6'($urandom);
      end else begin
         w.year   = 8'($urandom_range(70, 199));
         w.month  = 4'($urandom_range(0, 11));
         w.day    = 5'($urandom_range(1, 31));
         w.hour   = 5'($urandom_range(0, 23));
         w.minute = 6'($urandom_range(0, 59));
         w.second = 6'($urandom_range(0, 60));
      end
      return w;
   endfunction

   // time fields of a load word are don't-care; toggle them anyway
   function automatic civil_word_type load_word(int idx, logic [31:0] start, logic [31:0] stop);
      civil_word_type w;
      w = rand_time(1'b1);
      w.func       = FUNC_LOAD;
      w.pair_index = 6'(idx);
      w.pair_start = start;
      w.pair_end   = stop;
      return w;
   endfunction

   // mostly plausible intervals, some arbitrary, some empty or reversed
   function automatic civil_word_type rand_load(int idx);
      int          mode;
      logic [31:0] start;
      logic [31:0] stop;
      longint      top;
      mode = $urandom_range(0, 9);
      if (mode == 0) begin
         start = $urandom;
         stop  = $urandom;
      end else if (mode == 1) begin
         stop  = $urandom_range(0, 32'hF400_0000);
         start = stop + 32'($urandom_range(0, 86400));
      end else begin
         start = $urandom_range(0, 32'hF400_0000);
         top   = longint'(start) + $urandom_range(1, 86400 * 200);
         stop  = (top > longint'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : top[31:0];
      end
      return load_word(idx, start, stop);
   endfunction

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------
   task automatic send_word(civil_word_type w);
      req_valid      <= 1'b1;
      req_func       <= w.func;
      req_year       <= w.year;
      req_month      <= w.month;
      req_day        <= w.day;
      req_hour       <= w.hour;
      req_minute     <= w.minute;
      req_second     <= w.second;
      req_pair_index <= w.pair_index;
      req_pair_start <= w.pair_start;
      req_pair_end   <= w.pair_end;
      // hold the word until an edge sees valid without stall
      do @(posedge clock); while (req_stall);
      sb.note_word(w);
   endtask

   // drop valid for a random burst now and then, then offer the word
   task automatic offer(civil_word_type w);
      int gap;
      if (req_idle_on && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, GAP_MAX);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      send_word(w);
   endtask

   // drain every awaited result, then let a late scan run out
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_INDEX_W-1:0] idx, int val);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= OFFSET_W'(val);
      @(posedge clock);
      sb.set_reg(idx, OFFSET_W'(val));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_offsets(int std_val, int dst_val, int count_val);
      write_reg(CSR_STD_OFFSET, std_val);
      write_reg(CSR_DST_OFFSET, dst_val);
      write_reg(CSR_PAIR_COUNT, count_val);
      settings++;
   endtask

   // Load an interval built around a civil time, then convert that time and
   // its neighbouring seconds, so both interval edges get hit.
   task automatic interval_probe();
      civil_word_type t;
      longint         s;
      longint         lo;
      longint         hi;
      int             a;
      int             b;
      int             idx;
      int             scan;
      t = rand_time(1'b0);
      s = epoch_ledger::civil_seconds(t);
      a = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 86400 * 30) : $urandom_range(0, 1);
      b = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 86400 * 30) : $urandom_range(0, 1);
      lo = (s - a < 0) ? 0 : s - a;
      hi = (s + b > longint'(32'hFFFF_FFFF)) ? longint'(32'hFFFF_FFFF) : s + b;
      scan = (sb.pairs_used < TABLE_DEPTH) ? int'(sb.pairs_used) : TABLE_DEPTH;
      idx = (scan == 0) ? $urandom_range(0, TABLE_DEPTH - 1) : $urandom_range(0, scan - 1);
      offer(load_word(idx, lo[31:0], hi[31:0]));
      offer(t);
      if (t.second > 6'd0) begin
         t.second = t.second - 6'd1;
         offer(t);
         t.second = t.second + 6'd1;
      end
      t.second = t.second + 6'd1;
      offer(t);
   endtask

   task automatic random_word();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         interval_probe();
      end else if (pick < 35) begin
         offer(rand_load($urandom_range(0, TABLE_DEPTH - 1)));
      end else begin
         offer(rand_time($urandom_range(0, 9) == 0));
      end
   endtask

   // -------------------------------------------------------------------------
   // Response side: random stall bursts, one long hold-off on request
   // -------------------------------------------------------------------------
   initial begin : result_side
      int stall_left;
      stall_left = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            sb.check_result(rsp_epoch_seconds, rsp_in_daylight);
         end
         if (hold_wanted) begin
            hold_wanted = 1'b0;
            stall_left = LONG_HOLD;
         end else if (stall_left == 0 && rsp_idle_on && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, GAP_MAX);
         end
         if (stall_left > 0) begin
            rsp_stall <= 1'b1;
            stall_left--;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // -------------------------------------------------------------------------
   // Watchdog: give up when no word moves on either channel for too long
   // -------------------------------------------------------------------------
   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < STALL_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("no word moved for %0d cycles", STALL_LIMIT);
      $display("CHECK FAILED");
      $finish;
   end

   // -------------------------------------------------------------------------
   // Main sequence
   // -------------------------------------------------------------------------
   initial begin : stimulus
      civil_word_type t;
      longint         s;
      int             p;
      int             n;
      int             i;
      int             std_val;
      int             dst_val;
      int             count_val;

      sb = new();
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Out of reset: GMT, no intervals scanned. Hit the calendar corners.
      offer(civil_time(70, 0, 1, 0, 0, 0));           // the epoch itself
      offer(civil_time(0, 0, 0, 0, 0, 0));            // all-zero fields, negative sum
      offer(civil_time(70, 0, 0, 0, 0, 0));           // day zero counts as minus one day
      offer(civil_time(0, 11, 31, 0, 0, 0));          // before 1970: no whole years
      t = civil_time(255, 15, 31, 31, 63, 63);        // every field at its top
      t.pair_index = '1;
      t.pair_start = '1;
      t.pair_end   = '1;
      offer(t);                                       // saturates high, month clamped
      offer(civil_time(200, 2, 1, 0, 0, 0));          // 2100 is not a leap year
      offer(civil_time(72, 1, 29, 23, 59, 60));       // leap day, leap second
      offer(civil_time(100, 11, 31, 12, 0, 0));       // 2000 is a leap year
      offer(civil_time(199, 11, 31, 23, 59, 59));     // last second of 2099
      offer(load_word(0, '0, '0));
      offer(load_word(TABLE_DEPTH - 1, '1, '1));

      // Fill the whole table so no scan ever reads an unwritten entry.
      for (i = 0; i < TABLE_DEPTH; i++) begin
         offer(rand_load(i));
      end

      settle();
      set_offsets(3600, 7200, 64);
      write_reg(CSR_UNUSED, $urandom_range(0, 2 ** 18 - 1));   // ignored index

      // Interval edges: start is inclusive, end exclusive.
      t = civil_time(100, 1, 29, 12, 0, 0);
      s = epoch_ledger::civil_seconds(t);
      offer(load_word(0, s[31:0], 32'(s + 1)));
      offer(t);
      t.second = 6'd1;
      offer(t);
      // Two overlapping intervals near the epoch; the lower entry wins.
      offer(load_word(1, 32'd0, 32'd100));
      offer(load_word(2, 32'd0, 32'd1000));

      // Daylight match whose adjusted time goes negative.
      settle();
      set_offsets(-131072, 131071, 64);
      offer(civil_time(70, 0, 1, 0, 0, 30));

      // Negative standard time: zero without a scan, despite the match.
      settle();
      set_offsets(131071, -131072, 64);
      offer(civil_time(70, 0, 1, 0, 0, 30));
      offer(civil_time(255, 11, 31, 23, 59, 59));

      // Random phases, each under a fresh setting. Pause before every phase
      // until nothing is awaited; the last phase runs without idling.
      for (p = 0; p < PHASES; p++) begin
         settle();
         case (p)
            0: begin
               std_val = 3600;    dst_val = 0;       count_val = 64;
            end
            1: begin
               std_val = -131072; dst_val = 131071;  count_val = 127;
            end
            2: begin
               std_val = 131071;  dst_val = -131072; count_val = 1;
            end
            3: begin
               std_val = -3600;   dst_val = -7200;   count_val = 0;
            end
            4: begin
               // raw register patterns, upper count bits included
               std_val   = $urandom_range(0, 2 ** 18 - 1);
               dst_val   = $urandom_range(0, 2 ** 18 - 1);
               count_val = $urandom_range(0, 2 ** 18 - 1);
            end
            default: begin
               std_val   = $urandom_range(0, 2 * 86400) - 86400;
               dst_val   = $urandom_range(0, 2 * 86400) - 86400;
               count_val = 64;
            end
         endcase
         set_offsets(std_val, dst_val, count_val);
         if (p == 4) begin
            write_reg(CSR_UNUSED, $urandom_range(0, 2 ** 18 - 1));
         end
         req_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         rsp_idle_on = (p != PHASES - 1) && ($urandom_range(0, 3) != 0);
         if (p == 2) begin
            // block the result side for a long stretch while words keep coming
            req_idle_on = 1'b0;
            hold_wanted = 1'b1;
         end
         for (n = 0; n < PHASE_WORDS; n++) begin
            random_word();
         end
      end

      settle();
      $display("Converted %0d times (%0d inside daylight, %0d clamped) across %0d table loads,",
               sb.n_convert, sb.n_daylight, sb.n_clamped, sb.n_load);
      $display("under %0d offset and entry-count settings including both offset extremes.",
               settings);
      if (sb.errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

[civil_time_to_epoch_seconds_unit.f]
+incdir+src
src/ctes_pkg.sv
src/ctes_ram.sv
src/civil_time_to_epoch_seconds_unit.sv
test/tb.sv
